[rtl/sdsh_pkg.sv]
package sdsh_pkg;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_RX    = 3'd3;
  localparam logic [2:0] OP_DATA  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_DATA   = 2'd2;
  localparam logic [1:0] ST_INIT   = 2'd3;

  localparam logic [2:0] CARD_NONE = 3'd0;
  localparam logic [2:0] CARD_MMC  = 3'd1;
  localparam logic [2:0] CARD_V1   = 3'd2;
  localparam logic [2:0] CARD_V2   = 3'd3;
  localparam logic [2:0] CARD_V2HC = 3'd4;

  typedef enum logic [4:0] {
    P_IDLE, P_WAKE, P_CMD0, P_CMD8, P_CMD8_TRAIL, P_V2_55, P_V2_41,
    P_CMD58, P_CMD58_TRAIL, P_V1_PROBE55, P_V1_PROBE41, P_V1_55, P_V1_41,
    P_MMC_1, P_CMD16,
    P_RD_CMD, P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_RD_STOP,
    P_WR_PRE55, P_WR_PRE23, P_WR_CMD, P_WR_READY, P_WR_TOKEN, P_WR_NEED,
    P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_STOP_READY, P_WR_STOP_TOKEN
  } phase_t;

  typedef enum logic [2:0] {
    E_NONE, E_READY, E_FRAME, E_STUFF, E_RESP, E_TRAIL
  } eng_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] sector;
    logic [7:0]  block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       slow_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       need_data;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] card_type;
  } out_word_t;

endpackage

[rtl/sd_card_spi_host_sequencer.sv]
// SD card SPI-mode host sequencer.
// in channel  (in_valid / in_stall / in_data): one word per event: a host
//   request (init, read, write), the byte returned by the last SPI exchange,
//   or a write data byte the block asked for with need_data.
// out channel (out_valid / out_stall / out_data): exactly one result word
//   per input word: next byte to exchange, chip select, slow clock, read
//   data, data request, completion status and card type.
// cfg_we / cfg_data write init_retry_limit (reset 65534); write only idle.
// Result path: an input register, then the result register after the
//   sequencing logic.
// Throughput: one word per cycle while the result is not stalled; SPI byte
//   exchange normally paces the words.
// Reset: the sequencer returns to idle with an unknown card type; the
//   retry limit returns to its default.
// Stall: a stalled result holds; the input register is taken in while the
//   result register is free or drains, so at most two words wait inside.
module sd_card_spi_host_sequencer
  import sdsh_pkg::*;
#(
  parameter int WAKE_CLOCK_BYTES = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int BLOCK_BYTES = 512;

  logic [15:0] init_retry_limit;
  logic        ir_valid;
  in_word_t    ir;
  logic        step;

  phase_t      phase, phase_next;
  eng_t        eng, eng_next;
  logic [2:0]  card_kind, card_kind_next;
  logic [5:0]  command_code, command_code_next;
  logic [31:0] command_argument, command_argument_next;
  logic [9:0]  byte_counter, byte_counter_next;
  logic [15:0] retry_counter, retry_counter_next;
  logic [7:0]  blocks_left, blocks_left_next;
  logic [7:0]  response_bytes [4];
  logic        rb_we;
  logic [1:0]  rb_idx;
  logic [7:0]  last_tx, last_tx_next;
  logic [31:0] xfer_address, xfer_address_next;
  logic        write_err, write_err_next;
  out_word_t   res;

  assign step     = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_retry_limit <= 16'd65534;
    end else if (cfg_we) begin
      init_retry_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ir <= in_data;
    end
  end

  always_comb begin
    logic [7:0]  rx;
    logic [7:0]  r1;
    logic        cmd_done;
    logic        tx_v;
    logic [7:0]  tx;
    logic [15:0] lim;
    logic [15:0] rc_inc;
    logic [7:0]  cnt;
    logic [7:0]  bl_dec;
    logic        ok;
    logic        start_c;
    logic [5:0]  sc_code;
    logic [31:0] sc_arg;
    logic        trail;
    logic [9:0]  bc_inc;
    logic [9:0]  fi;

    phase_next            = phase;
    eng_next              = eng;
    card_kind_next        = card_kind;
    command_code_next     = command_code;
    command_argument_next = command_argument;
    byte_counter_next     = byte_counter;
    retry_counter_next    = retry_counter;
    blocks_left_next      = blocks_left;
    last_tx_next          = last_tx;
    xfer_address_next     = xfer_address;
    write_err_next        = write_err;
    rb_we                 = 1'b0;
    rb_idx                = byte_counter[1:0];
    res                   = '0;
    rx       = ir.rx_byte;
    r1       = 8'd0;
    cmd_done = 1'b0;
    tx_v     = 1'b0;
    tx       = 8'hFF;
    start_c  = 1'b0;
    sc_code  = 6'd0;
    sc_arg   = 32'd0;
    trail    = 1'b0;
    lim      = (init_retry_limit == 16'd0) ? 16'd1 : init_retry_limit;
    rc_inc   = (retry_counter != 16'hFFFF) ? retry_counter + 16'd1 : retry_counter;
    cnt      = (ir.block_count == 8'd0) ? 8'd1 : ir.block_count;
    bl_dec   = (blocks_left != 8'd0) ? blocks_left - 8'd1 : 8'd0;
    ok       = (rx[4:0] == 5'h05);
    bc_inc   = byte_counter + 10'd1;
    fi       = 10'd0;

    if (ir.op <= OP_WRITE) begin
      if (phase == P_IDLE) begin
        if (ir.op == OP_INIT) begin
          card_kind_next     = CARD_NONE;
          retry_counter_next = 16'd0;
          byte_counter_next  = 10'd0;
          phase_next         = P_WAKE;
          tx_v = 1'b1;
        end else begin
          blocks_left_next  = cnt;
          xfer_address_next = (card_kind == CARD_V2HC) ? ir.sector : {ir.sector[22:0], 9'd0};
          start_c = 1'b1;
          sc_arg  = xfer_address_next;
          if (ir.op == OP_READ) begin
            phase_next = P_RD_CMD;
            sc_code    = (cnt == 8'd1) ? 6'd17 : 6'd18;
          end else if (cnt == 8'd1) begin
            phase_next = P_WR_CMD;
            sc_code    = 6'd24;
          end else if (card_kind != CARD_MMC) begin
            phase_next = P_WR_PRE55;
            sc_code    = 6'd55;
            sc_arg     = 32'd0;
          end else begin
            phase_next = P_WR_CMD;
            sc_code    = 6'd25;
          end
        end
      end else if (phase == P_WR_NEED) begin
        res.need_data = 1'b1;
      end else begin
        tx_v = 1'b1;
        tx   = last_tx;
      end
    end else if (ir.op == OP_RX && phase != P_IDLE && phase != P_WR_NEED) begin
      if (eng != E_NONE) begin
        case (eng)
          E_READY: begin
            tx_v = 1'b1;
            if (rx == 8'hFF) begin
              eng_next          = E_FRAME;
              byte_counter_next = 10'd0;
              fi                = 10'd0;
              tx                = 8'hFF;
            end
          end
          E_FRAME: begin
            byte_counter_next = bc_inc;
            tx_v = 1'b1;
            fi   = bc_inc;
            if (bc_inc >= 10'd6) begin
              eng_next = (command_code == 6'd12) ? E_STUFF : E_RESP;
            end
          end
          E_STUFF: begin
            eng_next = E_RESP;
            tx_v     = 1'b1;
          end
          E_RESP: begin
            if (rx[7]) begin
              tx_v = 1'b1;
            end else begin
              eng_next = E_NONE;
              cmd_done = 1'b1;
              r1       = rx;
            end
          end
          default: begin
            rb_we             = 1'b1;
            byte_counter_next = bc_inc;
            if (bc_inc < 10'd4) begin
              tx_v = 1'b1;
            end else begin
              eng_next = E_NONE;
              cmd_done = 1'b1;
            end
          end
        endcase
        if (eng == E_READY && rx == 8'hFF || eng == E_FRAME && bc_inc < 10'd6) begin
          case (fi[2:0])
            3'd0:    tx = {2'b01, command_code};
            3'd1:    tx = command_argument[31:24];
            3'd2:    tx = command_argument[23:16];
            3'd3:    tx = command_argument[15:8];
            3'd4:    tx = command_argument[7:0];
            default: tx = (command_code == 6'd0) ? 8'h95 :
                          (command_code == 6'd8) ? 8'h87 : 8'h01;
          endcase
        end
        if (cmd_done) begin
          case (phase)
            P_CMD0: begin
              start_c = 1'b1;
              if (r1 == 8'h01) begin
                phase_next = P_CMD8;
                sc_code    = 6'd8;
                sc_arg     = 32'h1AA;
              end
            end
            P_CMD8: begin
              if (r1 == 8'h01) begin
                phase_next = P_CMD8_TRAIL;
                trail      = 1'b1;
              end else begin
                phase_next = P_V1_PROBE55;
                start_c    = 1'b1;
                sc_code    = 6'd55;
              end
            end
            P_CMD8_TRAIL: begin
              start_c = 1'b1;
              sc_code = 6'd55;
              if (response_bytes[2] == 8'h01 && rx == 8'hAA) begin
                retry_counter_next = 16'd0;
                phase_next         = P_V2_55;
              end else begin
                phase_next = P_V1_PROBE55;
              end
            end
            P_V2_55: begin
              phase_next = P_V2_41;
              start_c    = 1'b1;
              sc_code    = 6'd41;
              sc_arg     = 32'h40000000;
            end
            P_V2_41: begin
              if (r1 == 8'd0) begin
                phase_next = P_CMD58;
                start_c    = 1'b1;
                sc_code    = 6'd58;
              end else begin
                retry_counter_next = rc_inc;
                if (rc_inc >= lim) begin
                  card_kind_next = CARD_NONE;
                  phase_next     = P_IDLE;
                  eng_next       = E_NONE;
                  res.done_res   = 1'b1;
                  res.status     = ST_INIT;
                end else begin
                  phase_next = P_V2_55;
                  start_c    = 1'b1;
                  sc_code    = 6'd55;
                end
              end
            end
            P_CMD58: begin
              if (r1 == 8'd0) begin
                phase_next = P_CMD58_TRAIL;
                trail      = 1'b1;
              end else begin
                card_kind_next = CARD_NONE;
                phase_next     = P_IDLE;
                res.done_res   = 1'b1;
                res.status     = ST_INIT;
              end
            end
            P_CMD58_TRAIL: begin
              card_kind_next = response_bytes[0][6] ? CARD_V2HC : CARD_V2;
              phase_next     = P_IDLE;
              res.done_res   = 1'b1;
              res.status     = ST_OK;
            end
            P_V1_PROBE55: begin
              phase_next = P_V1_PROBE41;
              start_c    = 1'b1;
              sc_code    = 6'd41;
            end
            P_V1_PROBE41: begin
              retry_counter_next = 16'd0;
              start_c            = 1'b1;
              if (r1 <= 8'd1) begin
                card_kind_next = CARD_V1;
                phase_next     = P_V1_55;
                sc_code        = 6'd55;
              end else begin
                card_kind_next = CARD_MMC;
                phase_next     = P_MMC_1;
                sc_code        = 6'd1;
              end
            end
            P_V1_55: begin
              phase_next = P_V1_41;
              start_c    = 1'b1;
              sc_code    = 6'd41;
            end
            P_V1_41, P_MMC_1: begin
              if (r1 == 8'd0) begin
                phase_next = P_CMD16;
                start_c    = 1'b1;
                sc_code    = 6'd16;
                sc_arg     = 32'(BLOCK_BYTES);
              end else begin
                retry_counter_next = rc_inc;
                if (rc_inc >= lim) begin
                  card_kind_next = CARD_NONE;
                  phase_next     = P_IDLE;
                  res.done_res   = 1'b1;
                  res.status     = ST_INIT;
                end else if (phase == P_V1_41) begin
                  phase_next = P_V1_55;
                  start_c    = 1'b1;
                  sc_code    = 6'd55;
                end else begin
                  start_c = 1'b1;
                  sc_code = 6'd1;
                end
              end
            end
            P_CMD16: begin
              phase_next   = P_IDLE;
              res.done_res = 1'b1;
              if (r1 == 8'd0) begin
                res.status = ST_OK;
              end else begin
                card_kind_next = CARD_NONE;
                res.status     = ST_INIT;
              end
            end
            P_RD_CMD: begin
              if (r1 != 8'd0) begin
                phase_next   = P_IDLE;
                res.done_res = 1'b1;
                res.status   = ST_REJECT;
              end else begin
                phase_next = P_RD_TOKEN;
                tx_v       = 1'b1;
              end
            end
            P_RD_STOP: begin
              phase_next   = P_IDLE;
              res.done_res = 1'b1;
              res.status   = ST_OK;
            end
            P_WR_PRE55: begin
              phase_next = P_WR_PRE23;
              start_c    = 1'b1;
              sc_code    = 6'd23;
              sc_arg     = {24'd0, blocks_left};
            end
            P_WR_PRE23: begin
              phase_next = P_WR_CMD;
              start_c    = 1'b1;
              sc_code    = 6'd25;
              sc_arg     = xfer_address;
            end
            P_WR_CMD: begin
              if (r1 != 8'd0) begin
                phase_next   = P_IDLE;
                res.done_res = 1'b1;
                res.status   = ST_REJECT;
              end else begin
                write_err_next = 1'b0;
                phase_next     = P_WR_READY;
                tx_v           = 1'b1;
              end
            end
            default: begin
              tx_v = 1'b1;
              tx   = last_tx;
            end
          endcase
        end
      end else begin
        case (phase)
          P_WAKE: begin
            byte_counter_next = bc_inc;
            if (bc_inc < 10'(WAKE_CLOCK_BYTES)) begin
              tx_v = 1'b1;
            end else begin
              phase_next = P_CMD0;
              start_c    = 1'b1;
            end
          end
          P_RD_TOKEN: begin
            if (rx == 8'hFE) begin
              phase_next        = P_RD_DATA;
              byte_counter_next = 10'd0;
            end
            tx_v = 1'b1;
          end
          P_RD_DATA: begin
            res.read_valid = 1'b1;
            res.read_byte  = rx;
            tx_v           = 1'b1;
            if (bc_inc >= 10'(BLOCK_BYTES)) begin
              phase_next        = P_RD_CRC;
              byte_counter_next = 10'd0;
            end else begin
              byte_counter_next = bc_inc;
            end
          end
          P_RD_CRC: begin
            byte_counter_next = bc_inc;
            if (bc_inc < 10'd2) begin
              tx_v = 1'b1;
            end else begin
              blocks_left_next = bl_dec;
              if (bl_dec != 8'd0) begin
                phase_next = P_RD_TOKEN;
                tx_v       = 1'b1;
              end else if (command_code == 6'd18) begin
                phase_next = P_RD_STOP;
                start_c    = 1'b1;
                sc_code    = 6'd12;
              end else begin
                phase_next   = P_IDLE;
                res.done_res = 1'b1;
                res.status   = ST_OK;
              end
            end
          end
          P_WR_READY: begin
            tx_v = 1'b1;
            if (rx == 8'hFF) begin
              phase_next = P_WR_TOKEN;
              tx         = (command_code == 6'd24) ? 8'hFE : 8'hFC;
            end
          end
          P_WR_TOKEN: begin
            phase_next        = P_WR_NEED;
            byte_counter_next = 10'd0;
            res.need_data     = 1'b1;
          end
          P_WR_DATA: begin
            if (bc_inc < 10'(BLOCK_BYTES)) begin
              byte_counter_next = bc_inc;
              phase_next        = P_WR_NEED;
              res.need_data     = 1'b1;
            end else begin
              byte_counter_next = 10'd0;
              phase_next        = P_WR_CRC;
              tx_v              = 1'b1;
            end
          end
          P_WR_CRC: begin
            byte_counter_next = bc_inc;
            if (bc_inc >= 10'd2) begin
              phase_next = P_WR_RESP;
            end
            tx_v = 1'b1;
          end
          P_WR_RESP: begin
            blocks_left_next = bl_dec;
            if (command_code == 6'd24) begin
              phase_next   = P_IDLE;
              res.done_res = 1'b1;
              res.status   = ok ? ST_OK : ST_DATA;
            end else begin
              if (!ok) begin
                write_err_next = 1'b1;
              end
              phase_next = (!ok || bl_dec == 8'd0) ? P_WR_STOP_READY : P_WR_READY;
              tx_v       = 1'b1;
            end
          end
          P_WR_STOP_READY: begin
            tx_v = 1'b1;
            if (rx == 8'hFF) begin
              phase_next = P_WR_STOP_TOKEN;
              tx         = 8'hFD;
            end
          end
          P_WR_STOP_TOKEN: begin
            phase_next   = P_IDLE;
            res.done_res = 1'b1;
            res.status   = write_err ? ST_DATA : ST_OK;
          end
          default: begin
            tx_v = 1'b1;
            tx   = last_tx;
          end
        endcase
      end
    end else if (ir.op == OP_DATA && phase == P_WR_NEED) begin
      phase_next = P_WR_DATA;
      tx_v       = 1'b1;
      tx         = ir.data_byte;
    end else if (phase == P_WR_NEED) begin
      res.need_data = 1'b1;
    end else if (phase != P_IDLE) begin
      tx_v = 1'b1;
      tx   = last_tx;
    end

    if (start_c) begin
      command_code_next     = sc_code;
      command_argument_next = sc_arg;
      eng_next              = E_READY;
      tx_v                  = 1'b1;
      tx                    = 8'hFF;
    end
    if (trail) begin
      byte_counter_next = 10'd0;
      eng_next          = E_TRAIL;
      tx_v              = 1'b1;
      tx                = 8'hFF;
    end
    if (res.done_res) begin
      eng_next = E_NONE;
    end
    if (tx_v) begin
      last_tx_next = tx;
    end

    res.tx_valid    = tx_v;
    res.tx_byte     = tx_v ? tx : 8'hFF;
    res.chip_select = (phase_next != P_IDLE) && (phase_next != P_WAKE);
    res.slow_clock  = (phase_next >= P_WAKE) && (phase_next <= P_CMD16);
    res.card_type   = card_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= P_IDLE;
      eng              <= E_NONE;
      card_kind        <= CARD_NONE;
      command_code     <= '0;
      command_argument <= '0;
      byte_counter     <= '0;
      retry_counter    <= '0;
      blocks_left      <= '0;
      last_tx          <= 8'hFF;
      xfer_address     <= '0;
      write_err        <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      eng              <= eng_next;
      card_kind        <= card_kind_next;
      command_code     <= command_code_next;
      command_argument <= command_argument_next;
      byte_counter     <= byte_counter_next;
      retry_counter    <= retry_counter_next;
      blocks_left      <= blocks_left_next;
      last_tx          <= last_tx_next;
      xfer_address     <= xfer_address_next;
      write_err        <= write_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && rb_we) begin
      response_bytes[rb_idx] <= ir.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= ir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule

[rtl/sdsh_checker.sv]
module sdsh_checker
  import sdsh_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_tx_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'hFF)
    else $error("tx byte not idle");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |-> out_data.status == ST_OK)
    else $error("status without done");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.chip_select && !out_data.need_data)
    else $error("done while card still selected");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind sd_card_spi_host_sequencer sdsh_checker u_sdsh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/sd_card_spi_host_sequencer_tb.sv]
`timescale 1ns / 1ps

module sd_card_spi_host_sequencer_tb;
  import sdsh_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic [15:0] cfg_data;

  sd_card_spi_host_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  localparam int WAKE_BYTES = 10;
  localparam int SECTOR_BYTES = 512;
  localparam int WATCHDOG = 20000;

  typedef enum logic [2:0] {
    EN_NONE, EN_READY, EN_FRAME, EN_STUFF, EN_RESP, EN_TRAIL
  } cmd_eng_t;

  // sequencer model state
  logic [15:0] retry_limit;
  phase_t      seq_phase;
  logic [2:0]  kind;
  logic [5:0]  cmd_code;
  logic [31:0] cmd_arg;
  logic [15:0] bcount;
  logic [15:0] retries;
  logic [7:0]  blocks;
  logic [7:0]  resp [4];
  cmd_eng_t    cmd_eng;
  logic [7:0]  prev_tx;
  logic [31:0] addr;
  logic        wr_err;
  out_word_t   nxt;

  out_word_t expected_words[$];
  int        errors;
  int        idle_cycles;
  int        sent;
  bit        in_gaps;
  bit        out_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] frame_at(int i);
    case (i)
      0: return {2'b01, cmd_code};
      1: return cmd_arg[31:24];
      2: return cmd_arg[23:16];
      3: return cmd_arg[15:8];
      4: return cmd_arg[7:0];
      default: begin
        if (cmd_code == 6'd0) return 8'h95;
        if (cmd_code == 6'd8) return 8'h87;
        return 8'h01;
      end
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    nxt.tx_valid = 1'b1;
    nxt.tx_byte = b;
    prev_tx = b;
  endtask

  task automatic issue_cmd(logic [5:0] code, logic [31:0] arg);
    cmd_code = code;
    cmd_arg = arg;
    cmd_eng = EN_READY;
    send_byte(8'hFF);
  endtask

  task automatic issue_trail();
    bcount = '0;
    cmd_eng = EN_TRAIL;
    send_byte(8'hFF);
  endtask

  task automatic complete(logic [1:0] st);
    seq_phase = P_IDLE;
    cmd_eng = EN_NONE;
    nxt.done_res = 1'b1;
    nxt.status = st;
  endtask

  task automatic fail_init();
    kind = CARD_NONE;
    complete(ST_INIT);
  endtask

  function automatic bit polls_spent();
    logic [15:0] lim;
    lim = (retry_limit != 0) ? retry_limit : 16'd1;
    if (retries != 16'hFFFF) retries++;
    return retries >= lim;
  endfunction

  task automatic on_response(logic [7:0] r1);
    case (seq_phase)
      P_CMD0:
        if (r1 == 8'h01) begin
          seq_phase = P_CMD8;
          issue_cmd(6'd8, 32'h1AA);
        end else issue_cmd(6'd0, 0);
      P_CMD8:
        if (r1 == 8'h01) begin
          seq_phase = P_CMD8_TRAIL;
          issue_trail();
        end else begin
          seq_phase = P_V1_PROBE55;
          issue_cmd(6'd55, 0);
        end
      P_CMD8_TRAIL:
        if (resp[2] == 8'h01 && resp[3] == 8'hAA) begin
          retries = '0;
          seq_phase = P_V2_55;
          issue_cmd(6'd55, 0);
        end else begin
          seq_phase = P_V1_PROBE55;
          issue_cmd(6'd55, 0);
        end
      P_V2_55: begin
        seq_phase = P_V2_41;
        issue_cmd(6'd41, 32'h40000000);
      end
      P_V2_41:
        if (r1 == 0) begin
          seq_phase = P_CMD58;
          issue_cmd(6'd58, 0);
        end else if (polls_spent()) fail_init();
        else begin
          seq_phase = P_V2_55;
          issue_cmd(6'd55, 0);
        end
      P_CMD58:
        if (r1 == 0) begin
          seq_phase = P_CMD58_TRAIL;
          issue_trail();
        end else fail_init();
      P_CMD58_TRAIL: begin
        kind = resp[0][6] ? CARD_V2HC : CARD_V2;
        complete(ST_OK);
      end
      P_V1_PROBE55: begin
        seq_phase = P_V1_PROBE41;
        issue_cmd(6'd41, 0);
      end
      P_V1_PROBE41: begin
        retries = '0;
        if (r1 <= 1) begin
          kind = CARD_V1;
          seq_phase = P_V1_55;
          issue_cmd(6'd55, 0);
        end else begin
          kind = CARD_MMC;
          seq_phase = P_MMC_1;
          issue_cmd(6'd1, 0);
        end
      end
      P_V1_55: begin
        seq_phase = P_V1_41;
        issue_cmd(6'd41, 0);
      end
      P_V1_41, P_MMC_1:
        if (r1 == 0) begin
          seq_phase = P_CMD16;
          issue_cmd(6'd16, SECTOR_BYTES);
        end else if (polls_spent()) fail_init();
        else if (seq_phase == P_V1_41) begin
          seq_phase = P_V1_55;
          issue_cmd(6'd55, 0);
        end else issue_cmd(6'd1, 0);
      P_CMD16:
        if (r1 == 0) complete(ST_OK);
        else fail_init();
      P_RD_CMD:
        if (r1 != 0) complete(ST_REJECT);
        else begin
          seq_phase = P_RD_TOKEN;
          send_byte(8'hFF);
        end
      P_RD_STOP: complete(ST_OK);
      P_WR_PRE55: begin
        seq_phase = P_WR_PRE23;
        issue_cmd(6'd23, {24'd0, blocks});
      end
      P_WR_PRE23: begin
        seq_phase = P_WR_CMD;
        issue_cmd(6'd25, addr);
      end
      P_WR_CMD:
        if (r1 != 0) complete(ST_REJECT);
        else begin
          wr_err = 1'b0;
          seq_phase = P_WR_READY;
          send_byte(8'hFF);
        end
      default: send_byte(prev_tx);
    endcase
  endtask

  task automatic engine_step(logic [7:0] rx);
    case (cmd_eng)
      EN_READY:
        if (rx == 8'hFF) begin
          cmd_eng = EN_FRAME;
          bcount = '0;
          send_byte(frame_at(0));
        end else send_byte(8'hFF);
      EN_FRAME: begin
        bcount++;
        if (bcount < 6) send_byte(frame_at(bcount));
        else begin
          cmd_eng = (cmd_code == 6'd12) ? EN_STUFF : EN_RESP;
          send_byte(8'hFF);
        end
      end
      EN_STUFF: begin
        cmd_eng = EN_RESP;
        send_byte(8'hFF);
      end
      EN_RESP:
        if (rx[7]) send_byte(8'hFF);
        else begin
          cmd_eng = EN_NONE;
          on_response(rx);
        end
      default: begin
        resp[bcount[1:0]] = rx;
        bcount++;
        if (bcount < 4) send_byte(8'hFF);
        else begin
          cmd_eng = EN_NONE;
          on_response(8'h00);
        end
      end
    endcase
  endtask

  task automatic data_step(logic [7:0] rx);
    bit ok;
    case (seq_phase)
      P_WAKE: begin
        bcount++;
        if (bcount < WAKE_BYTES) send_byte(8'hFF);
        else begin
          seq_phase = P_CMD0;
          issue_cmd(6'd0, 0);
        end
      end
      P_RD_TOKEN: begin
        if (rx == 8'hFE) begin
          seq_phase = P_RD_DATA;
          bcount = '0;
        end
        send_byte(8'hFF);
      end
      P_RD_DATA: begin
        nxt.read_valid = 1'b1;
        nxt.read_byte = rx;
        bcount++;
        if (bcount >= SECTOR_BYTES) begin
          seq_phase = P_RD_CRC;
          bcount = '0;
        end
        send_byte(8'hFF);
      end
      P_RD_CRC: begin
        bcount++;
        if (bcount < 2) send_byte(8'hFF);
        else begin
          if (blocks != 0) blocks--;
          if (blocks != 0) begin
            seq_phase = P_RD_TOKEN;
            send_byte(8'hFF);
          end else if (cmd_code == 6'd18) begin
            seq_phase = P_RD_STOP;
            issue_cmd(6'd12, 0);
          end else complete(ST_OK);
        end
      end
      P_WR_READY:
        if (rx == 8'hFF) begin
          seq_phase = P_WR_TOKEN;
          send_byte(cmd_code == 6'd24 ? 8'hFE : 8'hFC);
        end else send_byte(8'hFF);
      P_WR_TOKEN: begin
        seq_phase = P_WR_NEED;
        bcount = '0;
        nxt.need_data = 1'b1;
      end
      P_WR_DATA: begin
        bcount++;
        if (bcount < SECTOR_BYTES) begin
          seq_phase = P_WR_NEED;
          nxt.need_data = 1'b1;
        end else begin
          seq_phase = P_WR_CRC;
          bcount = '0;
          send_byte(8'hFF);
        end
      end
      P_WR_CRC: begin
        bcount++;
        if (bcount >= 2) seq_phase = P_WR_RESP;
        send_byte(8'hFF);
      end
      P_WR_RESP: begin
        ok = (rx[4:0] == 5'h05);
        if (blocks != 0) blocks--;
        if (cmd_code == 6'd24) complete(ok ? ST_OK : ST_DATA);
        else begin
          if (!ok) wr_err = 1'b1;
          seq_phase = (!ok || blocks == 0) ? P_WR_STOP_READY : P_WR_READY;
          send_byte(8'hFF);
        end
      end
      P_WR_STOP_READY:
        if (rx == 8'hFF) begin
          seq_phase = P_WR_STOP_TOKEN;
          send_byte(8'hFD);
        end else send_byte(8'hFF);
      P_WR_STOP_TOKEN: complete(wr_err ? ST_DATA : ST_OK);
      default: send_byte(prev_tx);
    endcase
  endtask

  task automatic repeat_last();
    if (seq_phase == P_IDLE) return;
    if (seq_phase == P_WR_NEED) nxt.need_data = 1'b1;
    else send_byte(prev_tx);
  endtask

  task automatic begin_request(in_word_t w);
    if (w.op == OP_INIT) begin
      kind = CARD_NONE;
      retries = '0;
      bcount = '0;
      seq_phase = P_WAKE;
      send_byte(8'hFF);
      return;
    end
    blocks = (w.block_count != 0) ? w.block_count : 8'd1;
    addr = (kind == CARD_V2HC) ? w.sector : {w.sector[22:0], 9'd0};
    if (w.op == OP_READ) begin
      seq_phase = P_RD_CMD;
      issue_cmd(blocks == 1 ? 6'd17 : 6'd18, addr);
    end else if (blocks == 1) begin
      seq_phase = P_WR_CMD;
      issue_cmd(6'd24, addr);
    end else if (kind != CARD_MMC) begin
      seq_phase = P_WR_PRE55;
      issue_cmd(6'd55, 0);
    end else begin
      seq_phase = P_WR_CMD;
      issue_cmd(6'd25, addr);
    end
  endtask

  task automatic predict_word(in_word_t w);
    nxt = '0;
    nxt.tx_byte = 8'hFF;
    if (w.op <= OP_WRITE) begin
      if (seq_phase == P_IDLE) begin_request(w);
      else repeat_last();
    end else if (w.op == OP_RX && seq_phase != P_IDLE && seq_phase != P_WR_NEED) begin
      if (cmd_eng != EN_NONE) engine_step(w.rx_byte);
      else data_step(w.rx_byte);
    end else if (w.op == OP_DATA && seq_phase == P_WR_NEED) begin
      seq_phase = P_WR_DATA;
      send_byte(w.data_byte);
    end else repeat_last();
    if (!nxt.tx_valid) nxt.tx_byte = 8'hFF;
    if (!nxt.done_res) nxt.status = ST_OK;
    nxt.chip_select = (seq_phase != P_IDLE && seq_phase != P_WAKE);
    nxt.slow_clock = (seq_phase >= P_WAKE && seq_phase <= P_CMD16);
    nxt.card_type = kind;
    expected_words.push_back(nxt);
  endtask

  task automatic model_reset();
    retry_limit = 16'd65534;
    seq_phase = P_IDLE;
    kind = CARD_NONE;
    cmd_code = '0;
    cmd_arg = '0;
    bcount = '0;
    retries = '0;
    blocks = '0;
    for (int i = 0; i < 4; i++) resp[i] = '0;
    cmd_eng = EN_NONE;
    prev_tx = 8'hFF;
    addr = '0;
    wr_err = 1'b0;
  endtask

  // send one word and wait until it is accepted; valid stays up for the next word
  task automatic put_word(in_word_t w);
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    predict_word(w);
    sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    retry_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w.op = 3'($urandom_range(0, 7));
    w.sector = $urandom;
    w.block_count = 8'($urandom);
    w.rx_byte = 8'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  task automatic send_op(logic [2:0] op, logic [31:0] sec, logic [7:0] cnt, logic [7:0] rx,
                         logic [7:0] db);
    in_word_t w;
    w.op = op;
    w.sector = sec;
    w.block_count = cnt;
    w.rx_byte = rx;
    w.data_byte = db;
    put_word(w);
  endtask

  // card answer: chosen from the model's own command engine state and phase
  function automatic logic [7:0] card_reply(int flavor);
    case (cmd_eng)
      EN_READY: return ($urandom_range(0, 5) == 0) ? 8'h00 : 8'hFF;
      EN_FRAME, EN_STUFF: return 8'($urandom);
      EN_RESP: begin
        if ($urandom_range(0, 4) == 0) return 8'h80 | 8'($urandom);
        case (seq_phase)
          P_CMD0: return ($urandom_range(0, 5) == 0) ? 8'h05 : 8'h01;
          P_CMD8: return (flavor >= 2) ? 8'h01 : 8'h05;
          P_V2_41, P_V1_41, P_MMC_1:
            return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h01;
          P_V1_PROBE41: return (flavor == 0) ? 8'h04 : 8'h01;
          P_RD_CMD, P_WR_CMD: return ($urandom_range(0, 9) == 0) ? 8'h04 : 8'h00;
          P_CMD58, P_CMD16: return ($urandom_range(0, 9) == 0) ? 8'h04 : 8'h00;
          default: return 8'($urandom_range(0, 127));
        endcase
      end
      EN_TRAIL: begin
        if (seq_phase == P_CMD8_TRAIL && $urandom_range(0, 5) != 0)
          return (bcount == 2) ? 8'h01 : (bcount == 3) ? 8'hAA : 8'($urandom);
        if (seq_phase == P_CMD58_TRAIL)
          return (bcount == 0) ? ((flavor == 3) ? 8'hC0 : 8'h80) : 8'($urandom);
        return 8'($urandom);
      end
      default: begin
        case (seq_phase)
          P_RD_TOKEN: return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'hFE;
          P_WR_READY, P_WR_STOP_READY:
            return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'hFF;
          P_WR_RESP: return ($urandom_range(0, 5) == 0) ? 8'h0B : 8'hE5;
          default: return 8'($urandom);
        endcase
      end
    endcase
  endfunction

  // run the current request to completion with occasional noise
  task automatic run_request(int flavor, int noise_pct);
    in_word_t w;
    while (seq_phase != P_IDLE) begin
      w = noise_word();
      if ($urandom_range(0, 99) >= noise_pct) begin
        if (seq_phase == P_WR_NEED) w.op = OP_DATA;
        else begin
          w.op = OP_RX;
          w.rx_byte = card_reply(flavor);
        end
      end
      put_word(w);
    end
  endtask

  task automatic do_init(int flavor);
    send_op(OP_INIT, 32'd0, 8'd0, 8'd0, 8'd0);
    run_request(flavor, 0);
  endtask

  task automatic test_directed();
    send_op(OP_RX, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_DATA, 32'd0, 8'd0, 8'd0, 8'hFF);
    send_op(3'd7, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(3'd5, 32'd0, 8'd0, 8'd0, 8'd0);
    send_op(OP_READ, 32'hFFFFFFFF, 8'd0, 8'h00, 8'h00);
    send_op(OP_WRITE, 32'h80000000, 8'd1, 8'h00, 8'h00);
    run_request(2, 0);
    write_limit(16'd1);
    do_init(2);
    write_limit(16'd0);
    do_init(0);
    write_limit(16'd3);
    do_init(1);
    write_limit(16'hFFFF);
    do_init(3);
  endtask

  task automatic test_random(int item_target, bit gaps);
    int flavor;
    logic [2:0] op;
    in_gaps = gaps;
    out_gaps = gaps;
    while (sent < item_target) begin
      if (expected_words.size() == 0 && seq_phase == P_IDLE && $urandom_range(0, 7) == 0)
        write_limit($urandom_range(0, 1) ? 16'($urandom_range(1, 6)) : 16'($urandom));
      flavor = $urandom_range(0, 3);
      op = (kind == CARD_NONE || $urandom_range(0, 1) == 0) ? OP_INIT : 3'($urandom_range(1, 2));
      send_op(op, $urandom, 8'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0)
        send_op(3'($urandom_range(0, 2)), $urandom, 8'($urandom), 8'd0, 8'd0);
      run_request(flavor, 5);
    end
  endtask

  initial begin
    errors = 0;
    sent = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    model_reset();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(1350, 1'b1);
    test_random(1800, 1'b0);
    wait_drain();
    if (errors == 0) $display("sd_card_spi_host_sequencer: match");
    else $display("sd_card_spi_host_sequencer: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (out_gaps && $urandom_range(0, 7) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0 && out_gaps) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, out_data);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data !== exp_w) begin
          $display("%0t expected %h actual %h", $time, exp_w, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("sd_card_spi_host_sequencer: mismatch");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule
